// ----- sv/dlq_pkg.sv -----
package dlq_pkg;

  localparam int QUEUE_DEPTH = 16;

  localparam logic [1:0] OP_SCHEDULE   = 2'd0;
  localparam logic [1:0] OP_UNSCHEDULE = 2'd1;
  localparam logic [1:0] OP_TICK       = 2'd2;

  typedef enum logic [1:0] {
    KIND_ACCEPT  = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    M_SCHED,
    M_UNSCHED,
    M_TICK,
    M_FULL,
    M_NONE
  } mode_t;

  typedef struct packed {
    logic signed [31:0] delta;
    logic [15:0]        timer;
    logic [7:0]         owner;
  } entry_t;

endpackage

// ----- sv/delta_list_timeout_queue_top.sv -----
// channel | ports                                             | handshake
// in      | in_opcode in_timer_id in_owner_id in_interval     | in_valid / in_stall
// out     | out_kind out_expired_id out_expired_owner         | out_valid / out_stall
//         | out_removed_count out_last                        |
// cfg     | cfg_tick_step                                     | cfg_valid / cfg_ready
//
// Schedule, unschedule and tick items walk the pending list through the entry RAM,
// one entry per cycle unless out_stall pauses a tick walk, in the steps accept,
// read lead-in, one step per entry, walk drain and finish. Full-list, empty-tick and
// unused-opcode items skip the walk and go from accept straight to finish.
// Synchronous active-low reset empties the list and sets tick_step to 1.
// out_stall pauses a tick walk while an expired item waits in the result register,
// and holds finish until the result register is free.
module delta_list_timeout_queue_top #(
  parameter int QUEUE_DEPTH = dlq_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_timer_id,
  input  logic [7:0]  in_owner_id,
  input  logic [30:0] in_interval,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_expired_id,
  output logic [7:0]  out_expired_owner,
  output logic [4:0]  out_removed_count,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_tick_step
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [15:0]     tick_step_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  dlq_pkg::entry_t mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  dlq_pkg::entry_t mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_step_r <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      tick_step_r <= cfg_tick_step;
    end
  end

  dlq_mem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dlq_ctrl #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_timer_id       (in_timer_id),
    .in_owner_id       (in_owner_id),
    .in_interval       (in_interval),
    .tick_step         (tick_step_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_expired_id    (out_expired_id),
    .out_expired_owner (out_expired_owner),
    .out_removed_count (out_removed_count),
    .out_last          (out_last),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_re            (mem_re),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata)
  );

endmodule

// ----- sv/dlq_mem.sv -----
module dlq_mem #(
  parameter int DEPTH = dlq_pkg::QUEUE_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  dlq_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output dlq_pkg::entry_t rdata
);

  dlq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/dlq_ctrl.sv -----
module dlq_ctrl #(
  parameter int DEPTH = dlq_pkg::QUEUE_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_opcode,
  input  logic [15:0]     in_timer_id,
  input  logic [7:0]      in_owner_id,
  input  logic [30:0]     in_interval,
  input  logic [15:0]     tick_step,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_kind,
  output logic [15:0]     out_expired_id,
  output logic [7:0]      out_expired_owner,
  output logic [4:0]      out_removed_count,
  output logic            out_last,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output dlq_pkg::entry_t mem_wdata,
  output logic            mem_re,
  output logic [AW-1:0]   mem_raddr,
  input  dlq_pkg::entry_t mem_rdata
);

  dlq_pkg::state_t state_r, state_nxt;
  dlq_pkg::mode_t  mode_r, mode_nxt;
  logic [15:0]        id_r, id_nxt;
  logic [7:0]         own_r, own_nxt;
  logic signed [31:0] rel_r, rel_nxt;
  logic signed [31:0] pend_r, pend_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      ri_r, ri_nxt;
  logic [CW-1:0]      wi_r, wi_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic               ins_r, ins_nxt;
  logic               exp_r, exp_nxt;
  logic               dv_r, dv_nxt;
  logic               hold_v_r, hold_v_nxt;
  logic [15:0]        hold_id_r, hold_id_nxt;
  logic [7:0]         hold_own_r, hold_own_nxt;
  dlq_pkg::entry_t    carry_r, carry_nxt;

  logic               out_valid_r, out_valid_nxt;
  dlq_pkg::kind_t     kind_r, kind_nxt;
  logic [15:0]        oid_r, oid_nxt;
  logic [7:0]         oown_r, oown_nxt;
  logic [4:0]         orem_r, orem_nxt;
  logic               olast_r, olast_nxt;

  logic in_accept;
  logic out_free;
  logic need_out;
  logic adv;
  logic walk_done;

  assign in_stall  = (state_r != dlq_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign need_out  = (mode_r == dlq_pkg::M_TICK) && hold_v_r && exp_r;
  assign adv       = !dv_r || !need_out || out_free;
  assign walk_done = !dv_r && (ri_r == cnt_r);

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_expired_id    = oid_r;
  assign out_expired_owner = oown_r;
  assign out_removed_count = orem_r;
  assign out_last          = olast_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dlq_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (mode_nxt == dlq_pkg::M_FULL || mode_nxt == dlq_pkg::M_NONE) begin
            state_nxt = dlq_pkg::ST_FINISH;
          end else begin
            state_nxt = dlq_pkg::ST_WALK;
          end
        end
      end
      dlq_pkg::ST_WALK: begin
        if (walk_done) begin
          state_nxt = dlq_pkg::ST_FINISH;
        end
      end
      dlq_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = dlq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dlq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    logic signed [31:0] d;
    logic signed [31:0] dt;
    mode_nxt      = mode_r;
    id_nxt        = id_r;
    own_nxt       = own_r;
    rel_nxt       = rel_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    ri_nxt        = ri_r;
    wi_nxt        = wi_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    ins_nxt       = ins_r;
    exp_nxt       = exp_r;
    dv_nxt        = dv_r;
    hold_v_nxt    = hold_v_r;
    hold_id_nxt   = hold_id_r;
    hold_own_nxt  = hold_own_r;
    carry_nxt     = carry_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    oid_nxt       = oid_r;
    oown_nxt      = oown_r;
    orem_nxt      = orem_r;
    olast_nxt     = olast_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    d             = mem_rdata.delta;
    dt            = (idx_r == '0) ? (d - $signed({16'b0, tick_step})) : d;

    unique case (state_r)
      dlq_pkg::ST_IDLE: begin
        if (in_valid) begin
          priority if (in_opcode == dlq_pkg::OP_SCHEDULE) begin
            mode_nxt = (cnt_r == CW'(DEPTH)) ? dlq_pkg::M_FULL : dlq_pkg::M_SCHED;
          end else if (in_opcode == dlq_pkg::OP_UNSCHEDULE) begin
            mode_nxt = dlq_pkg::M_UNSCHED;
          end else if (in_opcode == dlq_pkg::OP_TICK && cnt_r != '0) begin
            mode_nxt = dlq_pkg::M_TICK;
          end else begin
            mode_nxt = dlq_pkg::M_NONE;
          end
          id_nxt     = in_timer_id;
          own_nxt    = in_owner_id;
          rel_nxt    = $signed({1'b0, in_interval});
          pend_nxt   = '0;
          ri_nxt     = '0;
          wi_nxt     = '0;
          rem_nxt    = '0;
          ins_nxt    = 1'b0;
          exp_nxt    = 1'b1;
          dv_nxt     = 1'b0;
          hold_v_nxt = 1'b0;
        end
      end

      dlq_pkg::ST_WALK: begin
        if (dv_r && adv) begin
          unique case (mode_r)
            dlq_pkg::M_SCHED: begin
              if (ins_r) begin
                mem_we    = 1'b1;
                mem_waddr = idx_r;
                mem_wdata = carry_r;
                carry_nxt = mem_rdata;
              end else if (rel_r < d) begin
                mem_we          = 1'b1;
                mem_waddr       = idx_r;
                mem_wdata       = '{delta: rel_r, timer: id_r, owner: own_r};
                carry_nxt       = mem_rdata;
                carry_nxt.delta = d - rel_r;
                ins_nxt         = 1'b1;
              end else begin
                rel_nxt = rel_r - d;
              end
            end
            dlq_pkg::M_UNSCHED: begin
              if (mem_rdata.timer == id_r && mem_rdata.owner == own_r) begin
                pend_nxt = pend_r + d;
                rem_nxt  = rem_r + 1'b1;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = wi_r[AW-1:0];
                mem_wdata       = mem_rdata;
                mem_wdata.delta = d + pend_r;
                wi_nxt          = wi_r + 1'b1;
                pend_nxt        = '0;
              end
            end
            dlq_pkg::M_TICK: begin
              if (exp_r && dt <= 0) begin
                if (hold_v_r) begin
                  out_valid_nxt = 1'b1;
                  kind_nxt      = dlq_pkg::KIND_EXPIRED;
                  oid_nxt       = hold_id_r;
                  oown_nxt      = hold_own_r;
                  orem_nxt      = '0;
                  olast_nxt     = 1'b0;
                end
                hold_v_nxt   = 1'b1;
                hold_id_nxt  = mem_rdata.timer;
                hold_own_nxt = mem_rdata.owner;
              end else begin
                exp_nxt         = 1'b0;
                mem_we          = 1'b1;
                mem_waddr       = wi_r[AW-1:0];
                mem_wdata       = mem_rdata;
                mem_wdata.delta = dt;
                wi_nxt          = wi_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
        if (adv) begin
          if (ri_r < cnt_r) begin
            mem_re    = 1'b1;
            mem_raddr = ri_r[AW-1:0];
            idx_nxt   = ri_r[AW-1:0];
            ri_nxt    = ri_r + 1'b1;
            dv_nxt    = 1'b1;
          end else begin
            dv_nxt = 1'b0;
          end
        end
      end

      dlq_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          oid_nxt       = '0;
          oown_nxt      = '0;
          orem_nxt      = '0;
          olast_nxt     = 1'b1;
          unique case (mode_r)
            dlq_pkg::M_SCHED: begin
              mem_we    = 1'b1;
              mem_waddr = cnt_r[AW-1:0];
              mem_wdata = ins_r ? carry_r
                                : dlq_pkg::entry_t'{delta: rel_r, timer: id_r, owner: own_r};
              cnt_nxt   = cnt_r + 1'b1;
              kind_nxt  = dlq_pkg::KIND_ACCEPT;
            end
            dlq_pkg::M_UNSCHED: begin
              cnt_nxt  = wi_r;
              kind_nxt = dlq_pkg::KIND_ACCEPT;
              orem_nxt = 5'(rem_r);
            end
            dlq_pkg::M_TICK: begin
              cnt_nxt = wi_r;
              if (hold_v_r) begin
                kind_nxt = dlq_pkg::KIND_EXPIRED;
                oid_nxt  = hold_id_r;
                oown_nxt = hold_own_r;
              end else begin
                kind_nxt = dlq_pkg::KIND_NONE;
              end
              hold_v_nxt = 1'b0;
            end
            dlq_pkg::M_FULL: kind_nxt = dlq_pkg::KIND_FULL;
            default:         kind_nxt = dlq_pkg::KIND_NONE;
          endcase
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dlq_pkg::ST_IDLE;
      mode_r      <= dlq_pkg::M_NONE;
      cnt_r       <= '0;
      ri_r        <= '0;
      wi_r        <= '0;
      rem_r       <= '0;
      ins_r       <= 1'b0;
      exp_r       <= 1'b0;
      dv_r        <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      ri_r        <= ri_nxt;
      wi_r        <= wi_nxt;
      rem_r       <= rem_nxt;
      ins_r       <= ins_nxt;
      exp_r       <= exp_nxt;
      dv_r        <= dv_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    own_r      <= own_nxt;
    rel_r      <= rel_nxt;
    pend_r     <= pend_nxt;
    idx_r      <= idx_nxt;
    hold_id_r  <= hold_id_nxt;
    hold_own_r <= hold_own_nxt;
    carry_r    <= carry_nxt;
    kind_r     <= kind_nxt;
    oid_r      <= oid_nxt;
    oown_r     <= oown_nxt;
    orem_r     <= orem_nxt;
    olast_r    <= olast_nxt;
  end

endmodule

// ----- sv/dlq_checker.sv -----
module dlq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [15:0] out_expired_id,
  input logic [7:0]  out_expired_owner,
  input logic [4:0]  out_removed_count,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out item dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_kind) && $stable(out_expired_id)
      && $stable(out_last))
    else $error("out item changed under stall");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != dlq_pkg::KIND_EXPIRED |-> out_last)
    else $error("single-result item without last");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != dlq_pkg::KIND_EXPIRED
      |-> out_expired_id == 16'd0 && out_expired_owner == 8'd0)
    else $error("expiry fields set on non-expiry item");

  a_removed_only_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != dlq_pkg::KIND_ACCEPT |-> out_removed_count == 5'd0)
    else $error("removed count on non-accept item");

endmodule

bind delta_list_timeout_queue_top dlq_checker u_dlq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_kind          (out_kind),
  .out_expired_id    (out_expired_id),
  .out_expired_owner (out_expired_owner),
  .out_removed_count (out_removed_count),
  .out_last          (out_last)
);
